// ===== design/pidcs_pkg.sv =====
// Shared types, constants and helper functions for the PID step unit.
package pidcs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 82;
    localparam int GAIN_W    = 47;
    localparam int DIV_NUM_W = 67;
    localparam int DIV_W     = 33;

    localparam logic [2:0] REG_KP       = 3'd0;
    localparam logic [2:0] REG_KI       = 3'd1;
    localparam logic [2:0] REG_KD       = 3'd2;
    localparam logic [2:0] REG_SAMPLE_T = 3'd3;
    localparam logic [2:0] REG_TAU      = 3'd4;
    localparam logic [2:0] REG_OUT_MAX  = 3'd5;
    localparam logic [2:0] REG_OUT_MIN  = 3'd6;
    localparam logic [2:0] REG_DERIV_EN = 3'd7;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic [30:0]        sample_time;
        logic [30:0]        tau;
        logic signed [31:0] out_max;
        logic signed [31:0] out_min;
        logic               derivative_enable;
    } cfg_t;

    function automatic logic [32:0] abs33(input logic [32:0] x);
        abs33 = x[32] ? 33'(-x) : x;
    endfunction

    function automatic logic signed [31:0] sat33(input logic [32:0] x);
        if (x[32] != x[31]) begin
            sat33 = x[32] ? SMIN : SMAX;
        end else begin
            sat33 = x[31:0];
        end
    endfunction

    function automatic logic signed [31:0] satmag(input logic neg,
                                                  input logic [ACC_W-1:0] mag);
        if (!neg) begin
            satmag = (mag > ACC_W'(SMAX)) ? SMAX : mag[31:0];
        end else begin
            satmag = (mag > (ACC_W'(1) << (DATA_W-1))) ? SMIN : 32'(-mag[31:0]);
        end
    endfunction

endpackage

// ===== design/pid_controller_step_unit.sv =====
// Top level of the PID step unit: sequencer and datapath around one multiplier.
//
// One sample per transfer on the req channel (setpoint, measured), one result
// per sample on the rsp channel (drive), both valid/ready.
// req_ready is high only while the sequencer is idle, so a new sample is taken
// only after the last one has left the sequencer. A sample runs through the
// sequencer steps around the single 33x33 multiplier and through the bit-serial
// divider of the derivative filter (skipped when tau and sample_time are both zero).
// drive sits in an output register; the next sample is taken while it waits.
// If the receiver stalls, a finished sample holds in the last step until the
// output register frees up.
// The APB port writes gains, sample time, filter constant, output limits and
// the derivative enable; pready is always high. Write only while idle.
// Reset clears the integrator, filtered derivative, last error and last
// measurement, and loads the register defaults.
module pid_controller_step_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic signed [31:0]  setpoint,
    input  logic signed [31:0]  measured,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic signed [31:0]  drive
);

    localparam int ACC_W = pidcs_pkg::ACC_W;
    localparam int FB    = pidcs_pkg::FRAC_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ESUM  = 5'd1;
    localparam logic [4:0] S_PRND  = 5'd2;
    localparam logic [4:0] S_PSAT  = 5'd3;
    localparam logic [4:0] S_GRND  = 5'd4;
    localparam logic [4:0] S_GLO   = 5'd5;
    localparam logic [4:0] S_GHI   = 5'd6;
    localparam logic [4:0] S_GACC  = 5'd7;
    localparam logic [4:0] S_IRND  = 5'd8;
    localparam logic [4:0] S_ISAT  = 5'd9;
    localparam logic [4:0] S_IADD  = 5'd10;
    localparam logic [4:0] S_ICLMP = 5'd11;
    localparam logic [4:0] S_DM2   = 5'd12;
    localparam logic [4:0] S_DACC  = 5'd13;
    localparam logic [4:0] S_DABS  = 5'd14;
    localparam logic [4:0] S_DSTRT = 5'd15;
    localparam logic [4:0] S_DWAIT = 5'd16;
    localparam logic [4:0] S_YSUM  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    localparam logic [ACC_W-1:0] RND_P = ACC_W'(1) << (FB - 1);
    localparam logic [ACC_W-1:0] RND_I = ACC_W'(1) << FB;

    pidcs_pkg::cfg_t cfg;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic signed [31:0] e_reg;
    logic signed [31:0] ms_reg;
    logic [32:0]        dm_reg;
    logic [32:0]        s_reg;
    logic signed [31:0] p_reg;
    logic [pidcs_pkg::GAIN_W-1:0] gmag_reg;
    logic               gsign_reg;
    logic               psign_reg;
    logic               asign_reg;
    logic               nsign_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic signed [31:0] inc_reg;
    logic signed [31:0] hi_reg;
    logic signed [31:0] lo_reg;
    logic [33:0]        ysum_reg;

    logic signed [31:0] i_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] le_reg;
    logic signed [31:0] lm_reg;
    logic signed [31:0] drive_reg;
    logic               rsp_valid_reg;

    logic                           mul_en;
    logic [pidcs_pkg::MUL_W-1:0]    mul_a;
    logic [pidcs_pkg::MUL_W-1:0]    mul_b;
    logic [pidcs_pkg::PROD_W-1:0]   prod;
    logic [ACC_W-1:0]               prod_ext;
    logic [ACC_W-1:0]               rnd_p;

    logic        div_start;
    logic        div_done;
    logic        div_ovf;
    logic [33:0] div_mag;

    logic [32:0] den;
    logic [33:0] coef;
    logic [32:0] e_diff;
    logic [32:0] hi_diff;
    logic [32:0] lo_diff;
    logic [32:0] i_sum;
    logic        out_free;
    logic        accept;

    pidcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidcs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pidcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg[pidcs_pkg::DIV_NUM_W-1:0]),
        .den   (den),
        .done  (div_done),
        .ovf   (div_ovf),
        .mag   (div_mag)
    );

    assign den      = {1'b0, cfg.tau, 1'b0} + {2'b0, cfg.sample_time};
    assign coef     = {2'b0, cfg.tau, 1'b0} - {3'b0, cfg.sample_time};
    assign e_diff   = {setpoint[31], setpoint} - {measured[31], measured};
    assign hi_diff  = {cfg.out_max[31], cfg.out_max} - {p_reg[31], p_reg};
    assign lo_diff  = {cfg.out_min[31], cfg.out_min} - {p_reg[31], p_reg};
    assign i_sum    = {i_reg[31], i_reg} + {inc_reg[31], inc_reg};
    assign prod_ext = {{(ACC_W - pidcs_pkg::PROD_W){1'b0}}, prod};
    assign rnd_p    = (prod_ext + RND_P) >> FB;
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;
    assign div_start = (state_reg == S_DSTRT);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign drive     = drive_reg;

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_ESUM:
            begin
                mul_en = 1'b1;
                mul_a  = pidcs_pkg::abs33({cfg.kp[31], cfg.kp});
                mul_b  = pidcs_pkg::abs33({e_reg[31], e_reg});
            end
            S_PRND:
            begin
                mul_en = 1'b1;
                mul_a  = pidcs_pkg::abs33({cfg.ki[31], cfg.ki});
                mul_b  = {2'b0, cfg.sample_time};
            end
            S_GLO:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, gmag_reg[31:0]};
                mul_b  = pidcs_pkg::abs33(s_reg);
            end
            S_GHI:
            begin
                mul_en = 1'b1;
                mul_a  = {18'b0, gmag_reg[46:32]};
                mul_b  = pidcs_pkg::abs33(s_reg);
            end
            S_ICLMP:
            begin
                mul_en = 1'b1;
                mul_a  = pidcs_pkg::abs33({cfg.kd, 1'b0});
                mul_b  = pidcs_pkg::abs33(dm_reg);
            end
            S_DM2:
            begin
                mul_en = 1'b1;
                mul_a  = coef[33] ? 33'(-coef) : coef[32:0];
                mul_b  = pidcs_pkg::abs33({d_reg[31], d_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_ESUM : S_IDLE;
            S_ESUM:  state_next = S_PRND;
            S_PRND:  state_next = S_PSAT;
            S_PSAT:  state_next = S_GRND;
            S_GRND:  state_next = S_GLO;
            S_GLO:   state_next = S_GHI;
            S_GHI:   state_next = S_GACC;
            S_GACC:  state_next = S_IRND;
            S_IRND:  state_next = S_ISAT;
            S_ISAT:  state_next = S_IADD;
            S_IADD:  state_next = S_ICLMP;
            S_ICLMP: state_next = S_DM2;
            S_DM2:   state_next = S_DACC;
            S_DACC:  state_next = S_DABS;
            S_DABS:  state_next = (den == '0) ? S_YSUM : S_DSTRT;
            S_DSTRT: state_next = S_DWAIT;
            S_DWAIT: state_next = div_done ? S_YSUM : S_DWAIT;
            S_YSUM:  state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            d_reg         <= '0;
            le_reg        <= '0;
            lm_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IADD)
            begin
                i_reg <= pidcs_pkg::sat33(i_sum);
            end
            else if (state_reg == S_ICLMP)
            begin
                if (i_reg > hi_reg)
                begin
                    i_reg <= hi_reg;
                end
                else if (i_reg < lo_reg)
                begin
                    i_reg <= lo_reg;
                end
            end
            if (state_reg == S_DABS && den == '0)
            begin
                d_reg <= '0;
            end
            else if (state_reg == S_DWAIT && div_done)
            begin
                d_reg <= pidcs_pkg::satmag(!nsign_reg,
                         div_ovf ? {ACC_W{1'b1}} : ACC_W'(div_mag));
            end
            if (state_reg == S_OUT && out_free)
            begin
                le_reg        <= e_reg;
                lm_reg        <= ms_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    e_reg  <= pidcs_pkg::sat33(e_diff);
                    ms_reg <= measured;
                    dm_reg <= {measured[31], measured} - {lm_reg[31], lm_reg};
                end
            end
            S_ESUM:
            begin
                s_reg     <= {e_reg[31], e_reg} + {le_reg[31], le_reg};
                psign_reg <= cfg.kp[31] ^ e_reg[31];
            end
            S_PRND:
            begin
                acc_reg   <= rnd_p;
                asign_reg <= psign_reg;
                psign_reg <= cfg.ki[31];
            end
            S_PSAT:
            begin
                p_reg <= pidcs_pkg::satmag(asign_reg, acc_reg);
            end
            S_GRND:
            begin
                gmag_reg  <= rnd_p[pidcs_pkg::GAIN_W-1:0];
                gsign_reg <= psign_reg;
            end
            S_GLO:
            begin
                psign_reg <= gsign_reg ^ s_reg[32];
            end
            S_GHI:
            begin
                acc_reg <= prod_ext;
            end
            S_GACC:
            begin
                acc_reg   <= acc_reg + (prod_ext << 32);
                asign_reg <= psign_reg;
            end
            S_IRND:
            begin
                acc_reg <= (acc_reg + RND_I) >> (FB + 1);
            end
            S_ISAT:
            begin
                inc_reg <= pidcs_pkg::satmag(asign_reg, acc_reg);
                hi_reg  <= ($signed(hi_diff) > 0) ? pidcs_pkg::sat33(hi_diff) : '0;
                lo_reg  <= lo_diff[32] ? pidcs_pkg::sat33(lo_diff) : '0;
            end
            S_ICLMP:
            begin
                psign_reg <= cfg.kd[31] ^ dm_reg[32];
            end
            S_DM2:
            begin
                acc_reg   <= psign_reg ? ACC_W'(-prod_ext) : prod_ext;
                psign_reg <= coef[33] ^ d_reg[31];
            end
            S_DACC:
            begin
                acc_reg <= psign_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
            end
            S_DABS:
            begin
                nsign_reg <= acc_reg[ACC_W-1];
                acc_reg   <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
            end
            S_YSUM:
            begin
                ysum_reg <= {{2{p_reg[31]}}, p_reg} + {{2{i_reg[31]}}, i_reg}
                          + (cfg.derivative_enable ? {{2{d_reg[31]}}, d_reg} : 34'd0);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if ($signed(ysum_reg) > $signed({{2{cfg.out_max[31]}}, cfg.out_max}))
                    begin
                        drive_reg <= cfg.out_max;
                    end
                    else if ($signed(ysum_reg) < $signed({{2{cfg.out_min[31]}},
                                                          cfg.out_min}))
                    begin
                        drive_reg <= cfg.out_min;
                    end
                    else
                    begin
                        drive_reg <= ysum_reg[31:0];
                    end
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_ESUM)
        else $error("accepted sample did not start the sequence");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait step");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

// ===== design/pidcs_mul.sv =====
// Shared 33x33 unsigned multiplier with registered product.
module pidcs_mul (
    input  logic                           clk,
    input  logic                           en,
    input  logic [pidcs_pkg::MUL_W-1:0]    a,
    input  logic [pidcs_pkg::MUL_W-1:0]    b,
    output logic [pidcs_pkg::PROD_W-1:0]   prod
);

    logic [pidcs_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {{pidcs_pkg::MUL_W{1'b0}}, a} * {{pidcs_pkg::MUL_W{1'b0}}, b};
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/pidcs_div.sv =====
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
module pidcs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pidcs_pkg::DIV_NUM_W-1:0]   num,
    input  logic [pidcs_pkg::DIV_W-1:0]       den,
    output logic                              done,
    output logic                              ovf,
    output logic [pidcs_pkg::DIV_W:0]         mag
);

    localparam int W = pidcs_pkg::DIV_W;
    localparam int DIV_NUM_W_TOP = pidcs_pkg::DIV_NUM_W - 1;

    logic         busy_reg;
    logic         rnd_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] q_reg;
    logic [W-1:0] sh_reg;
    logic [W-1:0] den_reg;
    logic         ovf_reg;
    logic [W:0]   mag_reg;

    logic [W:0]   shifted;
    logic [W+1:0] diff;

    assign shifted = {r_reg, sh_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= num[2*W-1:W];
            sh_reg  <= num[W-1:0];
            den_reg <= den;
            ovf_reg <= num[DIV_NUM_W_TOP:W] >= {1'b0, den};
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[W-2:0], 1'b0};
            if (!diff[W+1])
            begin
                r_reg <= diff[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
        else if (rnd_reg)
        begin
            mag_reg <= {1'b0, q_reg} + (W+1)'(r_reg >= (den_reg - r_reg));
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign mag  = mag_reg;

endmodule

// ===== design/pidcs_regs.sv =====
// APB configuration register file for the PID step unit.
module pidcs_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pidcs_pkg::cfg_t     cfg
);

    pidcs_pkg::cfg_t cfg_reg;
    logic [2:0]      idx;
    logic            wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp                <= '0;
            cfg_reg.ki                <= '0;
            cfg_reg.kd                <= '0;
            cfg_reg.sample_time       <= 31'd66;
            cfg_reg.tau               <= '0;
            cfg_reg.out_max           <= '0;
            cfg_reg.out_min           <= '0;
            cfg_reg.derivative_enable <= 1'b1;
        end
        else if (wr)
        begin
            unique case (idx)
                pidcs_pkg::REG_KP:       cfg_reg.kp                <= pwdata;
                pidcs_pkg::REG_KI:       cfg_reg.ki                <= pwdata;
                pidcs_pkg::REG_KD:       cfg_reg.kd                <= pwdata;
                pidcs_pkg::REG_SAMPLE_T: cfg_reg.sample_time       <= pwdata[30:0];
                pidcs_pkg::REG_TAU:      cfg_reg.tau               <= pwdata[30:0];
                pidcs_pkg::REG_OUT_MAX:  cfg_reg.out_max           <= pwdata;
                pidcs_pkg::REG_OUT_MIN:  cfg_reg.out_min           <= pwdata;
                pidcs_pkg::REG_DERIV_EN: cfg_reg.derivative_enable <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pidcs_pkg::REG_KP:       prdata = cfg_reg.kp;
            pidcs_pkg::REG_KI:       prdata = cfg_reg.ki;
            pidcs_pkg::REG_KD:       prdata = cfg_reg.kd;
            pidcs_pkg::REG_SAMPLE_T: prdata = {1'b0, cfg_reg.sample_time};
            pidcs_pkg::REG_TAU:      prdata = {1'b0, cfg_reg.tau};
            pidcs_pkg::REG_OUT_MAX:  prdata = cfg_reg.out_max;
            pidcs_pkg::REG_OUT_MIN:  prdata = cfg_reg.out_min;
            pidcs_pkg::REG_DERIV_EN: prdata = {31'b0, cfg_reg.derivative_enable};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sim/pid_controller_step_unit_test.sv =====
// Self-checking testbench for the PID step unit: APB setup, random samples, predicted drive.
module pid_controller_step_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned BIG_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;

    class pid_scoreboard;
        logic signed [31:0] kp, ki, kd, out_max, out_min;
        logic [30:0]        t_s, tau;
        bit                 d_en;
        longint             integ, dfilt, last_e, last_m;
        logic signed [31:0] drive_q[$];
        int                 errors;

        function new();
            kp = 0; ki = 0; kd = 0; out_max = 0; out_min = 0;
            t_s = 66; tau = 0; d_en = 1;
            integ = 0; dfilt = 0; last_e = 0; last_m = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                pidcs_pkg::REG_KP:       kp = v;
                pidcs_pkg::REG_KI:       ki = v;
                pidcs_pkg::REG_KD:       kd = v;
                pidcs_pkg::REG_SAMPLE_T: t_s = v[30:0];
                pidcs_pkg::REG_TAU:      tau = v[30:0];
                pidcs_pkg::REG_OUT_MAX:  out_max = v;
                pidcs_pkg::REG_OUT_MIN:  out_min = v;
                pidcs_pkg::REG_DERIV_EN: d_en = v[0];
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic signed [127:0] wmul(longint a, longint b);
            logic signed [127:0] x, y;
            x = a;
            y = b;
            return x * y;
        endfunction

        function longint round_div(logic signed [127:0] n, longint unsigned d);
            logic [127:0] m, q, r, dd;
            bit neg;
            neg = n < 0;
            m = neg ? -n : n;
            dd = {64'd0, d};
            q = m / dd;
            r = m % dd;
            if (r >= dd - r) q = q + 1;
            if (q > {64'd0, BIG_LIM}) q = {64'd0, BIG_LIM};
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function void note_sample(logic signed [31:0] sp, logic signed [31:0] ms);
            longint e, p, g, inc, hi, lo, y, omax, omin, msl, tsl, taul;
            longint unsigned den;
            logic signed [127:0] num;
            omax = out_max;
            omin = out_min;
            msl = ms;
            tsl = longint'(t_s);
            taul = longint'(tau);
            e = sat32(longint'(sp) - msl);
            p = sat32(round_div(wmul(kp, e), 65536));
            g = round_div(wmul(ki, tsl), 65536);
            inc = sat32(round_div(wmul(g, e + last_e), 131072));
            integ = sat32(integ + inc);
            hi = omax > p ? sat32(omax - p) : 0;
            lo = omin < p ? sat32(omin - p) : 0;
            if (integ > hi) integ = hi;
            else if (integ < lo) integ = lo;
            den = 2 * taul + tsl;
            if (den != 0) begin
                num = wmul(2 * longint'(kd), msl - last_m) + wmul(2 * taul - tsl, dfilt);
                dfilt = sat32(-round_div(num, den));
            end else begin
                dfilt = 0;
            end
            y = sat32(p + integ + (d_en ? dfilt : 0));
            if (y > omax) y = omax;
            else if (y < omin) y = omin;
            last_e = e;
            last_m = msl;
            drive_q.push_back(y[31:0]);
        endfunction

        function void check_drive(logic signed [31:0] got);
            logic signed [31:0] want;
            if (drive_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected drive %0d", got);
                return;
            end
            want = drive_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("drive mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               req_valid, req_ready;
    logic signed [31:0] setpoint, measured;
    logic               rsp_valid, rsp_ready;
    logic signed [31:0] drive;

    pid_scoreboard sb;
    int            cycles;

    pid_controller_step_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready),
        .setpoint(setpoint), .measured(measured),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .drive(drive)
    );

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            4: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid = 0;
        while (sb.drive_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_sample(logic [31:0] sp, logic [31:0] ms);
        int gap;
        @(negedge clk);
        req_valid = 1; setpoint = sp; measured = ms;
        do @(posedge clk); while (!req_ready);
        sb.note_sample(sp, ms);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            req_valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic configure(logic [31:0] g_p, logic [31:0] g_i, logic [31:0] g_d,
                             logic [31:0] ts, logic [31:0] tc, logic [31:0] hi,
                             logic [31:0] lo, logic [31:0] den);
        wait_idle();
        apb_write(pidcs_pkg::REG_KP, g_p);
        apb_write(pidcs_pkg::REG_KI, g_i);
        apb_write(pidcs_pkg::REG_KD, g_d);
        apb_write(pidcs_pkg::REG_SAMPLE_T, ts);
        apb_write(pidcs_pkg::REG_TAU, tc);
        apb_write(pidcs_pkg::REG_OUT_MAX, hi);
        apb_write(pidcs_pkg::REG_OUT_MIN, lo);
        apb_write(pidcs_pkg::REG_DERIV_EN, den);
    endtask

    task automatic random_burst(int n);
        logic [31:0] sp;
        repeat (n)
        begin
            sp = pick_value();
            if ($urandom_range(0, 3) == 0) send_sample(sp, pick_value());
            else send_sample(sp, sp + 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000));
        end
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0) begin
                rsp_ready = 0;
                stall--;
            end else begin
                rsp_ready = 1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready) sb.check_drive(drive);
        end
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req_valid = 0; setpoint = 0; measured = 0; rsp_ready = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_sample(32'h0001_0000, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);

        configure(32'h0002_0000, 32'h0010_0000, 32'h0000_8000, 32'h0000_0042, 32'h0000_0800,
                  32'h0064_0000, 32'hFF9C_0000, 1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h0001_8000, 32'hFFFF_8000);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF);

        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h1234_5678, 32'hEDCB_A987);

        // zero filter denominator, crossed limits, PI mode
        configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                  32'hFFFF_0000, 32'h0001_0000, 0);
        send_sample(32'h0003_0000, 32'h0);
        send_sample(32'hFFFD_0000, 32'h0);
        send_sample(32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        configure(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h1, 32'h0,
                  32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_sample(32'h0, 32'h0001_0000);
        send_sample(32'h0, 32'hFFFF_0000);

        repeat (8)
        begin
            configure(pick_value(), pick_value(), pick_value(),
                      $urandom_range(0, 7) == 0 ? 32'h7FFF_FFFF : $urandom_range(1, 32'h0001_0000),
                      $urandom_range(0, 3) == 0 ? 32'h0 : $urandom_range(0, 32'h0002_0000),
                      $urandom_range(0, 32'h7FFF_FFFF),
                      32'h8000_0000 | $urandom_range(0, 32'h7FFF_FFFF),
                      32'($urandom_range(0, 3) != 0));
            random_burst(170);
        end
        configure(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, 32'h42, 32'h200,
                  32'h000A_0000, 32'hFFF6_0000, 1);
        random_burst(270);

        @(negedge clk);
        req_valid = 0;
        while (sb.drive_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
